// ===== design/sfxd_pkg.sv =====
// ---------------------------------------------------------------------------
// sfxd_pkg
// Shared types and constants of the status frame deframer.
// ---------------------------------------------------------------------------
package sfxd_pkg;

  localparam int unsigned POS_W = 6;
  localparam int unsigned STATUS_W = 3;

  // Byte offsets in the frame
  localparam logic [POS_W-1:0] POS_HDR0  = 6'd0;
  localparam logic [POS_W-1:0] POS_HDR1  = 6'd1;
  localparam logic [POS_W-1:0] POS_XOR_FIRST = 6'd2;
  localparam logic [POS_W-1:0] POS_XOR_LAST  = 6'd47;
  localparam logic [POS_W-1:0] POS_SUM   = 6'd48;
  localparam logic [POS_W-1:0] POS_TAIL0 = 6'd49;
  localparam logic [POS_W-1:0] POS_TAIL1 = 6'd50;
  localparam logic [POS_W-1:0] FRAME_LEN = 6'd51;

  localparam logic [POS_W-1:0] POS_ADDR  = 6'd2;
  localparam logic [POS_W-1:0] POS_SEQ_LO = 6'd3;
  localparam logic [POS_W-1:0] POS_SEQ_HI = 6'd4;
  localparam logic [POS_W-1:0] POS_IR    = 6'd6;
  localparam logic [POS_W-1:0] POS_VIS   = 6'd10;
  localparam logic [POS_W-1:0] POS_AZ    = 6'd28;
  localparam logic [POS_W-1:0] POS_EL    = 6'd32;
  localparam logic [POS_W-1:0] POS_SELF  = 6'd36;
  localparam logic [POS_W-1:0] POS_IMG   = 6'd37;
  localparam logic [POS_W-1:0] POS_LINK  = 6'd38;
  localparam logic [POS_W-1:0] POS_TTEMP = 6'd39;
  localparam logic [POS_W-1:0] POS_CTEMP = 6'd40;

  localparam logic [7:0] SYNC_A = 8'h1F;
  localparam logic [7:0] SYNC_B = 8'hF1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_HDR  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_TAIL = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_SUM  = 3'd4;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Classified byte passed from front to back
  typedef struct packed {
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             last;
  } item_t;

endpackage

// ===== design/sfxd_front.sv =====
// ---------------------------------------------------------------------------
// sfxd_front
// Accepts bytes and tags each with its saturating frame position.
// ---------------------------------------------------------------------------
module sfxd_front
  import sfxd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       data_valid,
  output logic       data_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  logic [POS_W-1:0] pos;

  assign data_stall = q_full;
  assign q_push     = data_valid && !q_full;

  assign q_item.data = data_byte;
  assign q_item.pos  = pos;
  assign q_item.last = last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (q_push) begin
      if (last_byte) begin
        pos <= '0;
      end else if (pos < FRAME_LEN) begin
        pos <= pos + 6'd1;
      end
    end
  end

endmodule

// ===== design/sfxd_queue.sv =====
// ---------------------------------------------------------------------------
// sfxd_queue
// Short FIFO of classified items between front and back.
// ---------------------------------------------------------------------------
module sfxd_queue
  import sfxd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  item_t             entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (!push && pop) count <= count - 1'b1;
    end
  end

endmodule

// ===== design/sfxd_back.sv =====
// ---------------------------------------------------------------------------
// sfxd_back
// Checks header, tail and XOR checksum, captures fields, registers result.
// ---------------------------------------------------------------------------
module sfxd_back
  import sfxd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  item_t               head_item,
  output logic                pop,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [STATUS_W-1:0] frame_status,
  output logic [7:0]          device_address,
  output logic [15:0]         sequence_number,
  output logic [31:0]         infrared_focus_bits,
  output logic [31:0]         visible_focus_bits,
  output logic [31:0]         azimuth_bits,
  output logic [31:0]         elevation_bits,
  output logic [7:0]          self_check_byte,
  output logic [7:0]          image_state,
  output logic [7:0]          link_state,
  output logic signed [7:0]   tracker_temperature,
  output logic signed [7:0]   camera_temperature
);

  logic [7:0]       b;
  logic [POS_W-1:0] p;

  logic       header_fault;
  logic       tail_fault;
  logic [7:0] running_xor;
  logic [7:0] received_checksum;

  // captured fields
  logic [7:0]  cap_addr;
  logic [15:0] cap_seq;
  logic [31:0] cap_ir, cap_vis, cap_az, cap_el;
  logic [7:0]  cap_self, cap_img, cap_link, cap_ttemp, cap_ctemp;

  logic                emit;
  logic                hdr_now, tail_now;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    rel_ir, rel_vis, rel_az, rel_el;

  assign b = head_item.data;
  assign p = head_item.pos;

  // a last item needs the output register free
  assign pop  = head_valid && (!head_item.last || !result_valid || !result_stall);
  assign emit = pop && head_item.last;

  assign rel_ir  = p - POS_IR;
  assign rel_vis = p - POS_VIS;
  assign rel_az  = p - POS_AZ;
  assign rel_el  = p - POS_EL;

  always_comb begin
    hdr_now  = header_fault
             || ((p == POS_HDR0) && (b != SYNC_A))
             || ((p == POS_HDR1) && (b != SYNC_B));
    tail_now = tail_fault
             || ((p == POS_TAIL0) && (b != SYNC_B))
             || ((p == POS_TAIL1) && (b != SYNC_A));
    // position after this byte is below the frame length
    if (p < POS_TAIL1)                          status = ST_SHORT;
    else if (hdr_now)                           status = ST_BAD_HDR;
    else if (tail_now)                          status = ST_BAD_TAIL;
    else if (running_xor != received_checksum)  status = ST_BAD_SUM;
    else                                        status = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_fault <= 1'b0;
      tail_fault   <= 1'b0;
      running_xor  <= '0;
    end else if (pop) begin
      if (head_item.last) begin
        header_fault <= 1'b0;
        tail_fault   <= 1'b0;
        running_xor  <= '0;
      end else begin
        header_fault <= hdr_now;
        tail_fault   <= tail_now;
        if (p >= POS_XOR_FIRST && p <= POS_XOR_LAST) running_xor <= running_xor ^ b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (p == POS_SUM)    received_checksum <= b;
      if (p == POS_ADDR)   cap_addr <= b;
      if (p == POS_SEQ_LO) cap_seq[7:0] <= b;
      if (p == POS_SEQ_HI) cap_seq[15:8] <= b;
      if (p >= POS_IR && p < POS_IR + 6'd4)   cap_ir[{rel_ir[1:0], 3'b000} +: 8] <= b;
      if (p >= POS_VIS && p < POS_VIS + 6'd4) cap_vis[{rel_vis[1:0], 3'b000} +: 8] <= b;
      if (p >= POS_AZ && p < POS_AZ + 6'd4)   cap_az[{rel_az[1:0], 3'b000} +: 8] <= b;
      if (p >= POS_EL && p < POS_EL + 6'd4)   cap_el[{rel_el[1:0], 3'b000} +: 8] <= b;
      if (p == POS_SELF)  cap_self  <= b;
      if (p == POS_IMG)   cap_img   <= b;
      if (p == POS_LINK)  cap_link  <= b;
      if (p == POS_TTEMP) cap_ttemp <= b;
      if (p == POS_CTEMP) cap_ctemp <= b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // on a failed frame all fields read zero
  always_ff @(posedge clk) begin
    if (emit) begin
      frame_status <= status;
      if (status == ST_OK) begin
        device_address      <= cap_addr;
        sequence_number     <= cap_seq;
        infrared_focus_bits <= cap_ir;
        visible_focus_bits  <= cap_vis;
        azimuth_bits        <= cap_az;
        elevation_bits      <= cap_el;
        self_check_byte     <= cap_self;
        image_state         <= cap_img;
        link_state          <= cap_link;
        tracker_temperature <= cap_ttemp;
        camera_temperature  <= cap_ctemp;
      end else begin
        device_address      <= '0;
        sequence_number     <= '0;
        infrared_focus_bits <= '0;
        visible_focus_bits  <= '0;
        azimuth_bits        <= '0;
        elevation_bits      <= '0;
        self_check_byte     <= '0;
        image_state         <= '0;
        link_state          <= '0;
        tracker_temperature <= '0;
        camera_temperature  <= '0;
      end
    end
  end

endmodule

// ===== design/status_frame_xor_deframer_core.sv =====
// ---------------------------------------------------------------------------
// status_frame_xor_deframer_core
// Deframer for 51-byte status frames with XOR checksum.
// ---------------------------------------------------------------------------
// One byte is accepted per cycle while data_stall is low. Each byte is tagged with its
// frame position and passes through a two-item queue to the checker, so the
// last byte of a frame is registered in the queue before the checker writes
// its result to the output register. A stalled result holds the checker only when the
// next last byte reaches it; data_stall rises once the queue is full.
// Status codes: 0 ok, 1 short, 2 bad header, 3 bad tail, 4 checksum
// mismatch; every field but the status is zero when the status is not ok.
module status_frame_xor_deframer_core
  import sfxd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                data_valid,
  output logic                data_stall,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                result_valid,
  input  logic                result_stall,
  output logic [STATUS_W-1:0] frame_status,
  output logic [7:0]          device_address,
  output logic [15:0]         sequence_number,
  output logic [31:0]         infrared_focus_bits,
  output logic [31:0]         visible_focus_bits,
  output logic [31:0]         azimuth_bits,
  output logic [31:0]         elevation_bits,
  output logic [7:0]          self_check_byte,
  output logic [7:0]          image_state,
  output logic [7:0]          link_state,
  output logic signed [7:0]   tracker_temperature,
  output logic signed [7:0]   camera_temperature
);

  logic  q_full, q_push, q_pop, q_valid;
  item_t q_in, q_head;

  sfxd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_item     (q_in)
  );

  sfxd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  sfxd_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .head_valid          (q_valid),
    .head_item           (q_head),
    .pop                 (q_pop),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .frame_status        (frame_status),
    .device_address      (device_address),
    .sequence_number     (sequence_number),
    .infrared_focus_bits (infrared_focus_bits),
    .visible_focus_bits  (visible_focus_bits),
    .azimuth_bits        (azimuth_bits),
    .elevation_bits      (elevation_bits),
    .self_check_byte     (self_check_byte),
    .image_state         (image_state),
    .link_state          (link_state),
    .tracker_temperature (tracker_temperature),
    .camera_temperature  (camera_temperature)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the status frame deframer. Frames are built from a
// short table of directed cases (good, short, bad header/tail/checksum, long)
// and then from random frame mixes. A byte-level model of the deframer predicts
// the result of every untyped frame; results are checked field by field.
// ---------------------------------------------------------------------------
module tb;
  import sfxd_pkg::*;

  // Corruption flags for the frame builder
  localparam int FLT_NONE  = 0;
  localparam int FLT_HDR0  = 1;
  localparam int FLT_HDR1  = 2;
  localparam int FLT_TAIL0 = 4;
  localparam int FLT_TAIL1 = 8;
  localparam int FLT_SUM   = 16;
  localparam int FLT_ALL   = 31;

  localparam int RANDOM_BYTES = 1950;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_COUNT, FILL_RAND, FILL_NOISE} fill_t;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BLOCKS} rx_mode_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [7:0]          addr;
    logic [15:0]         seq;
    logic [31:0]         ir;
    logic [31:0]         vis;
    logic [31:0]         az;
    logic [31:0]         el;
    logic [7:0]          self_chk;
    logic [7:0]          img;
    logic [7:0]          link;
    logic signed [7:0]   ttemp;
    logic signed [7:0]   ctemp;
  } frame_result_t;

  typedef struct {
    int                  len;
    int                  flt;
    fill_t               fill;
    bit                  typed;
    logic [STATUS_W-1:0] exp_status;
  } frame_case_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                data_valid;
  logic                data_stall;
  logic [7:0]          data_byte;
  logic                last_byte;
  logic                result_valid;
  logic                result_stall;
  logic [STATUS_W-1:0] frame_status;
  logic [7:0]          device_address;
  logic [15:0]         sequence_number;
  logic [31:0]         infrared_focus_bits;
  logic [31:0]         visible_focus_bits;
  logic [31:0]         azimuth_bits;
  logic [31:0]         elevation_bits;
  logic [7:0]          self_check_byte;
  logic [7:0]          image_state;
  logic [7:0]          link_state;
  logic signed [7:0]   tracker_temperature;
  logic signed [7:0]   camera_temperature;

  // Deframer model state
  logic [POS_W-1:0] fr_pos;
  logic [7:0]       fr_xor;
  bit               fr_hdr_bad;
  bit               fr_tail_bad;
  logic [7:0]       fr_sum;
  logic [7:0]       fr_cap [64];

  frame_result_t expected_q [$];
  logic [7:0]    frame_q [$];
  int            errors = 0;
  int            bytes_sent = 0;
  int            burst_left = 0;
  rx_mode_t      rx_mode = RX_OPEN;
  int            rx_count = 0;

  frame_case_t directed_cases [17] = '{
    '{51,  FLT_NONE,                    FILL_ZERO,  1'b1, ST_OK},
    '{51,  FLT_NONE,                    FILL_ONES,  1'b1, ST_OK},
    '{51,  FLT_NONE,                    FILL_COUNT, 1'b0, ST_OK},
    '{51,  FLT_NONE,                    FILL_RAND,  1'b0, ST_OK},
    '{1,   FLT_NONE,                    FILL_RAND,  1'b1, ST_SHORT},
    '{1,   FLT_HDR0,                    FILL_RAND,  1'b1, ST_SHORT},
    '{50,  FLT_HDR1,                    FILL_ONES,  1'b1, ST_SHORT},
    '{2,   FLT_NONE,                    FILL_ZERO,  1'b1, ST_SHORT},
    '{51,  FLT_HDR0,                    FILL_RAND,  1'b1, ST_BAD_HDR},
    '{51,  FLT_HDR1 | FLT_TAIL0 | FLT_SUM, FILL_RAND, 1'b1, ST_BAD_HDR},
    '{51,  FLT_TAIL0,                   FILL_ONES,  1'b1, ST_BAD_TAIL},
    '{51,  FLT_TAIL1 | FLT_SUM,         FILL_ZERO,  1'b1, ST_BAD_TAIL},
    '{51,  FLT_SUM,                     FILL_ONES,  1'b1, ST_BAD_SUM},
    '{52,  FLT_NONE,                    FILL_RAND,  1'b0, ST_OK},
    '{100, FLT_NONE,                    FILL_COUNT, 1'b0, ST_OK},
    '{70,  FLT_SUM,                     FILL_RAND,  1'b1, ST_BAD_SUM},
    '{51,  FLT_NONE,                    FILL_ONES,  1'b1, ST_OK}
  };

  status_frame_xor_deframer_core i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .data_valid          (data_valid),
    .data_stall          (data_stall),
    .data_byte           (data_byte),
    .last_byte           (last_byte),
    .result_valid        (result_valid),
    .result_stall        (result_stall),
    .frame_status        (frame_status),
    .device_address      (device_address),
    .sequence_number     (sequence_number),
    .infrared_focus_bits (infrared_focus_bits),
    .visible_focus_bits  (visible_focus_bits),
    .azimuth_bits        (azimuth_bits),
    .elevation_bits      (elevation_bits),
    .self_check_byte     (self_check_byte),
    .image_state         (image_state),
    .link_state          (link_state),
    .tracker_temperature (tracker_temperature),
    .camera_temperature  (camera_temperature)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("tb failed");
    $finish;
  end

  task automatic flag_error(input string msg);
    if (errors < 40) $display("%0t mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  function automatic logic [31:0] cap_word(input logic [POS_W-1:0] p);
    return {fr_cap[p+3], fr_cap[p+2], fr_cap[p+1], fr_cap[p]};
  endfunction

  // Advances the deframer model by one byte; returns 1 when a frame result is due
  function automatic bit deframe_byte(input logic [7:0] b, input bit is_last,
                                      output frame_result_t res);
    logic [STATUS_W-1:0] st;
    res = '{default: 0};
    if (fr_pos < FRAME_LEN) begin
      if (fr_pos == POS_HDR0 && b != SYNC_A) fr_hdr_bad = 1'b1;
      if (fr_pos == POS_HDR1 && b != SYNC_B) fr_hdr_bad = 1'b1;
      if (fr_pos >= POS_XOR_FIRST && fr_pos <= POS_XOR_LAST) fr_xor ^= b;
      if (fr_pos >= POS_ADDR && fr_pos <= POS_CTEMP) fr_cap[fr_pos] = b;
      if (fr_pos == POS_SUM) fr_sum = b;
      if (fr_pos == POS_TAIL0 && b != SYNC_B) fr_tail_bad = 1'b1;
      if (fr_pos == POS_TAIL1 && b != SYNC_A) fr_tail_bad = 1'b1;
      fr_pos++;
    end
    if (!is_last) return 1'b0;
    if (fr_pos < FRAME_LEN) st = ST_SHORT;
    else if (fr_hdr_bad) st = ST_BAD_HDR;
    else if (fr_tail_bad) st = ST_BAD_TAIL;
    else if (fr_xor != fr_sum) st = ST_BAD_SUM;
    else st = ST_OK;
    res.status = st;
    if (st == ST_OK) begin
      res.addr     = fr_cap[POS_ADDR];
      res.seq      = {fr_cap[POS_SEQ_HI], fr_cap[POS_SEQ_LO]};
      res.ir       = cap_word(POS_IR);
      res.vis      = cap_word(POS_VIS);
      res.az       = cap_word(POS_AZ);
      res.el       = cap_word(POS_EL);
      res.self_chk = fr_cap[POS_SELF];
      res.img      = fr_cap[POS_IMG];
      res.link     = fr_cap[POS_LINK];
      res.ttemp    = fr_cap[POS_TTEMP];
      res.ctemp    = fr_cap[POS_CTEMP];
    end
    fr_pos      = '0;
    fr_xor      = '0;
    fr_hdr_bad  = 1'b0;
    fr_tail_bad = 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] fill_byte(input fill_t f, input int idx);
    case (f)
      FILL_ZERO:  return 8'h00;
      FILL_ONES:  return 8'hFF;
      FILL_COUNT: return idx[7:0];
      default: begin
        if ($urandom_range(0, 7) == 0) return {8{1'($urandom)}};
        return 8'($urandom);
      end
    endcase
  endfunction

  // Good frame first, then corruption, then trimming or padding to len; noise fill overwrites every byte
  task automatic build_frame(input int len, input int flt, input fill_t f);
    logic [7:0] sum;
    int         i;
    sum = '0;
    frame_q.delete();
    frame_q.push_back(SYNC_A);
    frame_q.push_back(SYNC_B);
    for (i = 2; i <= 47; i++) begin
      frame_q.push_back(fill_byte(f, i));
      sum ^= frame_q[i];
    end
    frame_q.push_back(sum);
    frame_q.push_back(SYNC_B);
    frame_q.push_back(SYNC_A);
    if (flt & FLT_HDR0)  frame_q[0]  ^= 8'($urandom_range(1, 255));
    if (flt & FLT_HDR1)  frame_q[1]  ^= 8'($urandom_range(1, 255));
    if (flt & FLT_TAIL0) frame_q[49] ^= 8'($urandom_range(1, 255));
    if (flt & FLT_TAIL1) frame_q[50] ^= 8'($urandom_range(1, 255));
    if (flt & FLT_SUM)   frame_q[48] ^= 8'($urandom_range(1, 255));
    while (frame_q.size() > len) void'(frame_q.pop_back());
    while (frame_q.size() < len) frame_q.push_back(fill_byte(f, frame_q.size()));
    if (f == FILL_NOISE) begin
      for (i = 0; i < frame_q.size(); i++) frame_q[i] = 8'($urandom);
    end
  endtask

  task automatic send_frame(input bit use_typed, input frame_result_t typed_res);
    frame_result_t res;
    bit            steady;
    bit            is_last;
    int            gap;
    int            i;
    steady = ($urandom_range(0, 3) == 0);
    for (i = 0; i < frame_q.size(); i++) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
          @(negedge clk);
          data_valid <= 1'b0;
          data_byte  <= 8'($urandom);
          last_byte  <= 1'($urandom);
          repeat (gap - 1) @(negedge clk);
        end
      end
      burst_left--;
      is_last = (i == frame_q.size() - 1);
      @(negedge clk);
      data_valid <= 1'b1;
      data_byte  <= frame_q[i];
      last_byte  <= is_last;
      do @(posedge clk); while (data_stall);
      bytes_sent++;
      if (deframe_byte(frame_q[i], is_last, res)) begin
        if (use_typed) expected_q.push_back(typed_res);
        else expected_q.push_back(res);
      end
    end
  endtask

  // Result side stall pattern: the mode is redrawn whenever its random countdown runs out
  always @(negedge clk) begin
    if (rx_count == 0) begin
      rx_mode  <= rx_mode_t'($urandom_range(0, 3));
      rx_count <= $urandom_range(20, 120);
    end else begin
      rx_count <= rx_count - 1;
    end
    case (rx_mode)
      RX_OPEN:   result_stall <= 1'b0;
      RX_LIGHT:  result_stall <= ($urandom_range(0, 3) == 0);
      RX_HEAVY:  result_stall <= 1'($urandom);
      RX_BLOCKS: result_stall <= (rx_count[3:0] < 4'd12);
      default:   result_stall <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_q.size() == 0) begin
        flag_error("result with no frame pending");
      end else begin
        want = expected_q.pop_front();
        check_field("frame_status", frame_status, want.status);
        check_field("device_address", device_address, want.addr);
        check_field("sequence_number", sequence_number, want.seq);
        check_field("infrared_focus_bits", infrared_focus_bits, want.ir);
        check_field("visible_focus_bits", visible_focus_bits, want.vis);
        check_field("azimuth_bits", azimuth_bits, want.az);
        check_field("elevation_bits", elevation_bits, want.el);
        check_field("self_check_byte", self_check_byte, want.self_chk);
        check_field("image_state", image_state, want.img);
        check_field("link_state", link_state, want.link);
        check_field("tracker_temperature", tracker_temperature, want.ttemp);
        check_field("camera_temperature", camera_temperature, want.ctemp);
      end
    end
  end

  initial begin
    frame_result_t typed_res;
    frame_case_t   fc;
    fill_t         f;
    int            kind;
    int            i;
    rst          = 1'b1;
    data_valid   = 1'b0;
    data_byte    = '0;
    last_byte    = 1'b0;
    result_stall = 1'b0;
    fr_pos       = '0;
    fr_xor       = '0;
    fr_hdr_bad   = 1'b0;
    fr_tail_bad  = 1'b0;
    fr_sum       = '0;
    for (i = 0; i < 64; i++) fr_cap[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_cases[i]) begin
      fc = directed_cases[i];
      typed_res = '{default: 0};
      typed_res.status = fc.exp_status;
      if (fc.exp_status == ST_OK && fc.fill == FILL_ONES) begin
        typed_res.addr     = 8'hFF;
        typed_res.seq      = 16'hFFFF;
        typed_res.ir       = 32'hFFFF_FFFF;
        typed_res.vis      = 32'hFFFF_FFFF;
        typed_res.az       = 32'hFFFF_FFFF;
        typed_res.el       = 32'hFFFF_FFFF;
        typed_res.self_chk = 8'hFF;
        typed_res.img      = 8'hFF;
        typed_res.link     = 8'hFF;
        typed_res.ttemp    = -8'sd1;
        typed_res.ctemp    = -8'sd1;
      end
      build_frame(fc.len, fc.flt, fc.fill);
      send_frame(fc.typed, typed_res);
    end

    typed_res = '{default: 0};
    while (bytes_sent < RANDOM_BYTES) begin
      case ($urandom_range(0, 9))
        0: f = FILL_ZERO;
        1: f = FILL_ONES;
        2: f = FILL_COUNT;
        default: f = FILL_RAND;
      endcase
      kind = $urandom_range(0, 99);
      if (kind < 65) build_frame(51, FLT_NONE, f);
      else if (kind < 75) build_frame(51, $urandom_range(1, FLT_ALL), f);
      else if (kind < 83) begin
        // short frames; tiny ones put back-to-back results on the output
        if ($urandom_range(0, 1)) build_frame($urandom_range(1, 4), FLT_NONE, f);
        else build_frame($urandom_range(5, 50), FLT_NONE, f);
      end else if (kind < 90) begin
        build_frame($urandom_range(52, 90),
                    ($urandom_range(0, 2) == 0) ? $urandom_range(1, FLT_ALL) : FLT_NONE, f);
      end else begin
        build_frame($urandom_range(1, 70), FLT_NONE, FILL_NOISE);
      end
      send_frame(1'b0, typed_res);
    end
    @(negedge clk);
    data_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
